FILE: hw/rtl/cwcrc_pkg.sv
`default_nettype none

package cwcrc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_WIDTH_MODE = 2'd1;
    localparam logic [1:0] CFG_POLYNOMIAL = 2'd2;

    // Width mode codes (code 3 behaves as the 8-bit mode)
    localparam logic [1:0] WM_32 = 2'd0;
    localparam logic [1:0] WM_16 = 2'd1;
    localparam logic [1:0] WM_8  = 2'd2;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DISABLED = 1'b1;

    localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;

    // Initial remainder at message start
    function automatic logic [31:0] crc_init(input logic [1:0] mode);
        logic [31:0] init;
        unique case (mode)
            WM_32:   init = 32'hFFFF_FFFF;
            WM_16:   init = 32'h0000_FFFF;
            default: init = 32'h0000_0000;
        endcase
        return init;
    endfunction

    // One byte through the CRC, MSB first, eight XOR-shift steps
    function automatic logic [31:0] crc_byte(
        input logic [31:0] rem,
        input logic [7:0]  data,
        input logic [1:0]  mode,
        input logic [31:0] poly
    );
        logic [31:0] mask;
        logic [31:0] top;
        logic [31:0] ins;
        logic [31:0] crc;
        logic [31:0] p;
        unique case (mode)
            WM_32:
            begin
                mask = 32'hFFFF_FFFF;
                top  = 32'h8000_0000;
                ins  = {data, 24'h00_0000};
            end
            WM_16:
            begin
                mask = 32'h0000_FFFF;
                top  = 32'h0000_8000;
                ins  = {16'h0000, data, 8'h00};
            end
            default:
            begin
                mask = 32'h0000_00FF;
                top  = 32'h0000_0080;
                ins  = {24'h00_0000, data};
            end
        endcase
        p   = poly & mask;
        crc = (rem & mask) ^ ins;
        for (int j = 0; j < 8; j++)
        begin
            if ((crc & top) != 32'h0)
            begin
                crc = ((crc << 1) ^ p) & mask;
            end
            else
            begin
                crc = (crc << 1) & mask;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/configurable_width_crc_engine_core.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        sink       in_valid / in_stall      data_byte[7:0], last
// out       source     out_valid / out_stall    crc_value[31:0], status
// cfg       sink       cfg_valid / cfg_ready    cfg_index[1:0], cfg_data[31:0]
//
// One item per cycle sustained while in_stall is low. Each item waits in the
// input register, where, if enabled, the byte-parallel CRC updates the
// remainder; a last-marked item's result is then loaded into the output
// register, raising out_valid (while disabled: the last result and DISABLED).
// in_stall rises only when a last-marked item is waiting and the output
// register is full and stalled. cfg_ready is always high. rst_n is asynchronous
// and resets all but the data registers; the polynomial resets to 0x04C11DB7.
module configurable_width_crc_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      crc_value,
    output logic             status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers
    logic        enable_reg;
    logic [1:0]  width_mode_reg;
    logic [31:0] polynomial_reg;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // CRC state
    logic [31:0] remainder_reg;
    logic [31:0] remainder_next;
    logic        mid_message_reg;
    logic        mid_message_next;
    logic [31:0] last_result_reg;
    logic [31:0] last_result_next;

    // Output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] crc_value_reg;
    logic [31:0] crc_value_next;
    logic        status_reg;
    logic        status_next;

    logic        out_free;
    logic        s1_fire;
    logic        in_take;
    logic [31:0] start_rem;
    logic [31:0] crc_new;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            width_mode_reg <= cwcrc_pkg::WM_32;
            polynomial_reg <= cwcrc_pkg::POLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cwcrc_pkg::CFG_ENABLE:     enable_reg     <= cfg_data[0];
                cwcrc_pkg::CFG_WIDTH_MODE: width_mode_reg <= cfg_data[1:0];
                cwcrc_pkg::CFG_POLYNOMIAL: polynomial_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Flow control: only a last-marked item needs the output register
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
    end

    // Byte-parallel CRC update
    assign start_rem = mid_message_reg ? remainder_reg
                                       : cwcrc_pkg::crc_init(width_mode_reg);
    assign crc_new   = cwcrc_pkg::crc_byte(start_rem, s1_byte_reg, width_mode_reg,
                                           polynomial_reg);

    always_comb
    begin
        remainder_next   = remainder_reg;
        mid_message_next = mid_message_reg;
        last_result_next = last_result_reg;
        out_valid_next   = out_valid_reg && out_stall;
        crc_value_next   = crc_value_reg;
        status_next      = status_reg;
        if (s1_fire)
        begin
            if (!enable_reg)
            begin
                mid_message_next = 1'b0;
                if (s1_last_reg)
                begin
                    out_valid_next = 1'b1;
                    crc_value_next = last_result_reg;
                    status_next    = cwcrc_pkg::STATUS_DISABLED;
                end
            end
            else
            begin
                remainder_next = crc_new;
                if (s1_last_reg)
                begin
                    mid_message_next = 1'b0;
                    last_result_next = crc_new;
                    out_valid_next   = 1'b1;
                    crc_value_next   = crc_new;
                    status_next      = cwcrc_pkg::STATUS_OK;
                end
                else
                begin
                    mid_message_next = 1'b1;
                end
            end
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg   <= 32'hFFFF_FFFF;
            mid_message_reg <= 1'b0;
            last_result_reg <= 32'h0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            remainder_reg   <= remainder_next;
            mid_message_reg <= mid_message_next;
            last_result_reg <= last_result_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_value_reg <= crc_value_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
